// ----- rtl/cfp_pkg.sv -----
`default_nettype none
package cfp_pkg;

	localparam int PAYLOAD_DEPTH = 64;
	localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
	localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
	localparam int BYTE_W        = 8;
	localparam int IDX_W         = 6;
	localparam int MAXLEN_W      = 7;
	localparam int STATUS_W      = 2;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 8;

	localparam logic [BYTE_W-1:0]   HEAD_RST   = 8'd239;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 7'd64;
	localparam logic [BYTE_W-1:0]   DEPTH_BYTE = BYTE_W'(PAYLOAD_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SUM_ERR = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_HEAD,
		OP_DEV,
		OP_SYS,
		OP_MSG,
		OP_SEQ,
		OP_LEN,
		OP_PAY,
		OP_CHK,
		OP_RD,
		OP_LD
	} cfp_op_t;

	typedef struct packed {
		cfp_op_t op;
	} cfp_cmd_t;

	typedef struct packed {
		logic head_match;
		logic len_zero;
		logic len_bad;
		logic pay_done;
		logic sum_ok;
		logic len_reg_zero;
		logic emit_last;
		logic out_free;
	} cfp_sts_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   device_id;
		logic [BYTE_W-1:0]   system_id;
		logic [BYTE_W-1:0]   message_id;
		logic [BYTE_W-1:0]   sequence_res;
		logic [BYTE_W-1:0]   payload_len;
		logic [IDX_W-1:0]    byte_index;
		logic [BYTE_W-1:0]   payload_byte;
		logic                has_byte;
		logic                last;
	} cfp_res_t;

endpackage
`default_nettype wire

// ----- rtl/cfp_if.sv -----
`default_nettype none
interface cfp_rx_if;
	logic                        valid;
	logic                        ready;
	logic [cfp_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
	logic                          valid;
	logic                          ready;
	logic [cfp_pkg::STATUS_W-1:0]  status;
	logic [cfp_pkg::BYTE_W-1:0]    device_id;
	logic [cfp_pkg::BYTE_W-1:0]    system_id;
	logic [cfp_pkg::BYTE_W-1:0]    message_id;
	logic [cfp_pkg::BYTE_W-1:0]    sequence_res;
	logic [cfp_pkg::BYTE_W-1:0]    payload_len;
	logic [cfp_pkg::IDX_W-1:0]     byte_index;
	logic [cfp_pkg::BYTE_W-1:0]    payload_byte;
	logic                          has_byte;
	logic                          last;

	modport source (
		output valid, output status, output device_id, output system_id,
		output message_id, output sequence_res, output payload_len,
		output byte_index, output payload_byte, output has_byte, output last,
		input ready
	);
	modport sink (
		input valid, input status, input device_id, input system_id,
		input message_id, input sequence_res, input payload_len,
		input byte_index, input payload_byte, input has_byte, input last,
		output ready
	);
endinterface

interface cfp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cfp_pkg::CFG_IDX_W-1:0]    index;
	logic [cfp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/cfp_ctrl.sv -----
`default_nettype none
module cfp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	input  wire cfp_pkg::cfp_sts_t sts,
	output cfp_pkg::cfp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_HUNT,
		S_DEV,
		S_SYS,
		S_MSG,
		S_SEQ,
		S_LEN,
		S_PAY,
		S_CHK,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t state_q;
	logic   receiving;
	logic   rx_fire;

	assign receiving = (state_q != S_EMIT_RD) && (state_q != S_EMIT_LD);
	assign rx_ready  = receiving && sts.out_free;
	assign rx_fire   = rx_valid && rx_ready;

	always_comb begin
		cmd.op = cfp_pkg::OP_NONE;
		case (state_q)
			S_HUNT:    if (rx_fire) cmd.op = cfp_pkg::OP_HEAD;
			S_DEV:     if (rx_fire) cmd.op = cfp_pkg::OP_DEV;
			S_SYS:     if (rx_fire) cmd.op = cfp_pkg::OP_SYS;
			S_MSG:     if (rx_fire) cmd.op = cfp_pkg::OP_MSG;
			S_SEQ:     if (rx_fire) cmd.op = cfp_pkg::OP_SEQ;
			S_LEN:     if (rx_fire) cmd.op = cfp_pkg::OP_LEN;
			S_PAY:     if (rx_fire) cmd.op = cfp_pkg::OP_PAY;
			S_CHK:     if (rx_fire) cmd.op = cfp_pkg::OP_CHK;
			S_EMIT_RD: if (sts.out_free) cmd.op = cfp_pkg::OP_RD;
			S_EMIT_LD: cmd.op = cfp_pkg::OP_LD;
			default:   cmd.op = cfp_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			case (state_q)
				S_HUNT: if (rx_fire && sts.head_match) state_q <= S_DEV;
				S_DEV:  if (rx_fire) state_q <= S_SYS;
				S_SYS:  if (rx_fire) state_q <= S_MSG;
				S_MSG:  if (rx_fire) state_q <= S_SEQ;
				S_SEQ:  if (rx_fire) state_q <= S_LEN;
				S_LEN: begin
					if (rx_fire) begin
						if (sts.len_zero) state_q <= S_CHK;
						else if (sts.len_bad) state_q <= S_HUNT;
						else state_q <= S_PAY;
					end
				end
				S_PAY: if (rx_fire && sts.pay_done) state_q <= S_CHK;
				S_CHK: begin
					if (rx_fire) begin
						if (sts.sum_ok && !sts.len_reg_zero) state_q <= S_EMIT_RD;
						else state_q <= S_HUNT;
					end
				end
				S_EMIT_RD: if (sts.out_free) state_q <= S_EMIT_LD;
				S_EMIT_LD: state_q <= sts.emit_last ? S_HUNT : S_EMIT_RD;
				default:   state_q <= S_HUNT;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cfp_dpath.sv -----
`default_nettype none
module cfp_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [cfp_pkg::BYTE_W-1:0]        rx_byte,
	input  wire cfp_pkg::cfp_cmd_t                 cmd,
	output cfp_pkg::cfp_sts_t                      sts,
	input  wire logic                              cfg_we,
	input  wire logic [cfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cfp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output cfp_pkg::cfp_res_t                      res
);

	logic [cfp_pkg::BYTE_W-1:0]   head_q;
	logic [cfp_pkg::MAXLEN_W-1:0] max_len_q;
	logic [cfp_pkg::BYTE_W-1:0]   dev_q;
	logic [cfp_pkg::BYTE_W-1:0]   sys_q;
	logic [cfp_pkg::BYTE_W-1:0]   msg_q;
	logic [cfp_pkg::BYTE_W-1:0]   seq_q;
	logic [cfp_pkg::BYTE_W-1:0]   len_q;
	logic [cfp_pkg::BYTE_W-1:0]   sum_q;
	logic [cfp_pkg::CNT_W-1:0]    cnt_q;
	logic [cfp_pkg::BYTE_W-1:0]   rd_data_q;
	logic [cfp_pkg::BYTE_W-1:0]   mem_q [cfp_pkg::PAYLOAD_DEPTH];
	logic                         res_valid_q;
	cfp_pkg::cfp_res_t            res_q;

	logic [cfp_pkg::BYTE_W-1:0]   sum_next;
	logic [cfp_pkg::BYTE_W-1:0]   cnt_inc;
	logic [cfp_pkg::ADDR_W-1:0]   addr;
	logic                         load;
	cfp_pkg::cfp_res_t            load_res;

	assign sum_next = sum_q + rx_byte;
	assign cnt_inc  = cfp_pkg::BYTE_W'(cnt_q) + 8'd1;
	assign addr     = cnt_q[cfp_pkg::ADDR_W-1:0];

	assign sts.head_match   = (rx_byte == head_q);
	assign sts.len_zero     = (rx_byte == '0);
	assign sts.len_bad      = (rx_byte > {1'b0, max_len_q}) || (rx_byte > cfp_pkg::DEPTH_BYTE);
	assign sts.pay_done     = (cnt_inc >= len_q);
	assign sts.sum_ok       = (rx_byte == sum_q);
	assign sts.len_reg_zero = (len_q == '0);
	assign sts.emit_last    = (cnt_inc == len_q);
	assign sts.out_free     = !res_valid_q || res_ready;

	// result formed from the latched header plus what the command selects
	always_comb begin
		load                  = 1'b0;
		load_res.status       = cfp_pkg::ST_GOOD;
		load_res.device_id    = dev_q;
		load_res.system_id    = sys_q;
		load_res.message_id   = msg_q;
		load_res.sequence_res = seq_q;
		load_res.payload_len  = len_q;
		load_res.byte_index   = '0;
		load_res.payload_byte = '0;
		load_res.has_byte     = 1'b0;
		load_res.last         = 1'b1;
		case (cmd.op)
			cfp_pkg::OP_LEN: begin
				load_res.payload_len = rx_byte;
				if (!sts.len_zero && sts.len_bad) begin
					load            = 1'b1;
					load_res.status = cfp_pkg::ST_LEN_ERR;
				end
			end
			cfp_pkg::OP_CHK: begin
				if (!sts.sum_ok) begin
					load            = 1'b1;
					load_res.status = cfp_pkg::ST_SUM_ERR;
				end else if (sts.len_reg_zero) begin
					load = 1'b1;
				end
			end
			cfp_pkg::OP_LD: begin
				load                  = 1'b1;
				load_res.byte_index   = cnt_q[cfp_pkg::IDX_W-1:0];
				load_res.payload_byte = rd_data_q;
				load_res.has_byte     = 1'b1;
				load_res.last         = sts.emit_last;
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= cfp_pkg::HEAD_RST;
			max_len_q   <= cfp_pkg::MAXLEN_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cfp_pkg::REG_HEAD_BYTE: head_q <= cfg_data;
					cfp_pkg::REG_MAX_LEN:   max_len_q <= cfg_data[cfp_pkg::MAXLEN_W-1:0];
					default: ;
				endcase
			end
			if (load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= load_res;
		case (cmd.op)
			cfp_pkg::OP_HEAD: if (sts.head_match) sum_q <= rx_byte;
			cfp_pkg::OP_DEV: begin
				dev_q <= rx_byte;
				sum_q <= sum_next;
			end
			cfp_pkg::OP_SYS: begin
				sys_q <= rx_byte;
				sum_q <= sum_next;
			end
			cfp_pkg::OP_MSG: begin
				msg_q <= rx_byte;
				sum_q <= sum_next;
			end
			cfp_pkg::OP_SEQ: begin
				seq_q <= rx_byte;
				sum_q <= sum_next;
			end
			cfp_pkg::OP_LEN: begin
				len_q <= rx_byte;
				sum_q <= sum_next;
				cnt_q <= '0;
			end
			cfp_pkg::OP_PAY: begin
				sum_q <= sum_next;
				cnt_q <= sts.pay_done ? '0 : cnt_inc[cfp_pkg::CNT_W-1:0];
			end
			cfp_pkg::OP_CHK: cnt_q <= '0;
			cfp_pkg::OP_LD:  cnt_q <= cnt_inc[cfp_pkg::CNT_W-1:0];
			default: ;
		endcase
	end

	// payload buffer
	always_ff @(posedge clk) begin
		if (cmd.op == cfp_pkg::OP_PAY) mem_q[addr] <= rx_byte;
		if (cmd.op == cfp_pkg::OP_RD) rd_data_q <= mem_q[addr];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ----- rtl/checksummed_frame_parser_core.sv -----
// Serial frame parser with an 8-bit additive checksum.
// rx: one received byte per transaction (valid/ready). The parser hunts for
// the head byte, latches device, system, message, sequence and length bytes,
// buffers the payload and checks the trailing sum byte.
// res: one transaction per result: a good frame gives one result per payload
// byte (last on the final one) or a single empty result for zero length;
// a length error or a sum mismatch gives one error result.
// cfg: register writes (index 0 head byte, 1 max payload length), always
// ready; write only while the parser is idle.
// Timing: an error or empty result is registered and shows on res the cycle
// after the byte that causes it. The first payload result of a good frame
// follows the sum byte through the registered read of the payload buffer and
// then the load of the output register; each further payload result takes
// another read and load, and a read waits while res holds an unaccepted
// result; rx ready is low until the last one is loaded.
// Stall: while a result waits on res, rx ready stays high only if res ready
// is high, so a stalled receiver holds back rx without losing data.
// Reset: asynchronous; the parser hunts for the head byte and the registers
// return to head 0xEF and limit 64. No buffer clearing is needed.
`default_nettype none
module checksummed_frame_parser_core (
	input  wire logic clk,
	input  wire logic arst_n,
	cfp_rx_if.sink    rx,
	cfp_res_if.source res,
	cfp_cfg_if.sink   cfg
);

	cfp_pkg::cfp_cmd_t cmd;
	cfp_pkg::cfp_sts_t sts;
	cfp_pkg::cfp_res_t res_d;
	logic              res_valid;

	assign cfg.ready = 1'b1;

	cfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.res       (res_d)
	);

	assign res.valid        = res_valid;
	assign res.status       = res_d.status;
	assign res.device_id    = res_d.device_id;
	assign res.system_id    = res_d.system_id;
	assign res.message_id   = res_d.message_id;
	assign res.sequence_res = res_d.sequence_res;
	assign res.payload_len  = res_d.payload_len;
	assign res.byte_index   = res_d.byte_index;
	assign res.payload_byte = res_d.payload_byte;
	assign res.has_byte     = res_d.has_byte;
	assign res.last         = res_d.last;

	// no byte is taken while an undelivered result would be overwritten
	a_rx_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |-> !res.valid || res.ready)
		else $error("rx accepted while result register full");

	// input stays closed between payload results of one frame
	a_emit_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.has_byte && !res.last |=> !rx.ready)
		else $error("rx opened in the middle of payload output");

	// only good frames carry payload bytes
	a_byte_good: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.has_byte |-> res.status == cfp_pkg::ST_GOOD)
		else $error("payload byte on an error result");

endmodule
`default_nettype wire
